@@ hdl/ffpa_pkg.sv @@
`default_nettype none
package ffpa_pkg;
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT    = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic       FUNC_ALLOC       = 1'b0;
  localparam logic       FUNC_FREE        = 1'b1;
  localparam logic [31:0] HEAP_BASE_RESET = 32'h8000_0000;
endpackage
`default_nettype wire

@@ hdl/first_fit_page_allocator_top.sv @@
`default_nettype none
// First-fit page allocator. The used map and the run lengths live in two
// single-port memories, one entry per page. After reset a clearing pass writes
// every entry to zero, during which no request is accepted (heap_base writes
// are taken). An allocate scans the map one page a cycle from page 0 until a
// long enough free run ends (if none does, it reports no fit), then writes
// the run back one page a cycle. A free reads the run length and clears its
// pages one a cycle. The scan over the used map sets the time of an allocate;
// one result leaves per request through an output register, and the next
// request is taken once it has been taken.
module first_fit_page_allocator_top #(
  parameter int PAGES     = 1024,
  parameter int PAGE_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [31:0] request_bytes,
  input  wire logic [31:0] free_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [31:0]      block_address,
  output logic [10:0]      page_count
);
  localparam int AW = $clog2(PAGES);
  localparam int CW = $clog2(PAGES + 1);
  localparam int NB = (33 - PAGE_BITS > CW) ? 33 - PAGE_BITS : CW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_FRD   = 3'd4;
  localparam logic [2:0] S_FCHK  = 3'd5;
  localparam logic [2:0] S_UNMK  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]    state;
  logic [31:0]   heap_base;
  logic          used_mem [PAGES];
  logic [CW-1:0] run_mem  [PAGES];
  logic          used_q;
  logic [CW-1:0] run_q;

  logic [CW:0]   addr;
  logic          rd_pending;
  logic [CW-1:0] need;
  logic [CW-1:0] run;
  logic [AW-1:0] start;
  logic [CW-1:0] left;
  logic [31:0]   req_addr;

  logic          used_we;
  logic          used_wd;
  logic [AW-1:0] used_a;
  logic          run_we;
  logic [CW-1:0] run_wd;
  logic [AW-1:0] run_a;

  logic [NB-1:0] need_full;
  logic [31:0]   off;
  logic [31:0]   off_page;

  assign need_full = NB'(({1'b0, request_bytes} + 33'((1 << PAGE_BITS) - 1)) >> PAGE_BITS);
  assign off       = free_address - heap_base;
  assign off_page  = off >> PAGE_BITS;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_a] <= used_wd;
    used_q <= used_mem[used_a];
    if (run_we) run_mem[run_a] <= run_wd;
    run_q <= run_mem[run_a];
  end

  always_comb begin
    used_we = 1'b0;
    used_wd = 1'b0;
    used_a  = addr[AW-1:0];
    run_we  = 1'b0;
    run_wd  = '0;
    run_a   = addr[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        used_we = 1'b1;
        run_we  = 1'b1;
      end
      S_MARK: begin
        used_we = 1'b1;
        used_wd = 1'b1;
        if (left == need) begin
          run_we = 1'b1;
          run_wd = need;
        end
      end
      S_FRD:  run_a = start;
      S_FCHK: run_a = start;
      S_UNMK: begin
        used_we = 1'b1;
        if (addr[AW-1:0] == start) run_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      heap_base <= ffpa_pkg::HEAP_BASE_RESET;
      addr      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) heap_base <= cfg_wdata;
      unique case (state)
        S_CLEAR: begin
          if (addr == (CW + 1)'(PAGES - 1)) begin
            state <= S_IDLE;
          end
          addr <= addr + 1'b1;
        end
        S_IDLE: begin
          if (in_valid) begin
            if (func == ffpa_pkg::FUNC_ALLOC) begin
              if (need_full == '0 || need_full > NB'(PAGES)) begin
                status        <= ffpa_pkg::STATUS_NO_FIT;
                block_address <= '0;
                page_count    <= '0;
                out_valid     <= 1'b1;
                state         <= S_OUT;
              end else begin
                need       <= CW'(need_full);
                run        <= '0;
                addr       <= '0;
                rd_pending <= 1'b0;
                state      <= S_SCAN;
              end
            end else begin
              req_addr <= free_address;
              if (off[PAGE_BITS-1:0] != '0 || off_page >= 32'(PAGES)) begin
                status        <= ffpa_pkg::STATUS_NOT_FOUND;
                block_address <= '0;
                page_count    <= '0;
                out_valid     <= 1'b1;
                state         <= S_OUT;
              end else begin
                start <= AW'(off_page);
                state <= S_FRD;
              end
            end
          end
        end
        S_SCAN: begin
          rd_pending <= (addr < (CW + 1)'(PAGES));
          addr       <= addr + 1'b1;
          if (rd_pending) begin
            if (used_q) begin
              run <= '0;
            end else begin
              run <= run + 1'b1;
              if (run + 1'b1 == need) begin
                start <= AW'(addr - 2'd1 - (CW + 1)'(need) + 1'b1);
                addr  <= (CW + 1)'(addr - 2'd1 - (CW + 1)'(need) + 1'b1);
                left  <= need;
                state <= S_MARK;
              end
            end
          end
          if (!rd_pending && addr > (CW + 1)'(PAGES)) begin
            status        <= ffpa_pkg::STATUS_NO_FIT;
            block_address <= '0;
            page_count    <= '0;
            out_valid     <= 1'b1;
            state         <= S_OUT;
          end
        end
        S_MARK: begin
          addr <= addr + 1'b1;
          left <= left - 1'b1;
          if (left == CW'(1)) begin
            status        <= ffpa_pkg::STATUS_OK;
            block_address <= heap_base + (32'(start) << PAGE_BITS);
            page_count    <= 11'(need);
            out_valid     <= 1'b1;
            state         <= S_OUT;
          end
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (run_q == '0) begin
            status        <= ffpa_pkg::STATUS_NOT_FOUND;
            block_address <= '0;
            page_count    <= '0;
            out_valid     <= 1'b1;
            state         <= S_OUT;
          end else begin
            need  <= run_q;
            left  <= run_q;
            addr  <= (CW + 1)'(start);
            state <= S_UNMK;
          end
        end
        S_UNMK: begin
          addr <= addr + 1'b1;
          left <= left - 1'b1;
          if (left == CW'(1) || addr == (CW + 1)'(PAGES - 1)) begin
            status        <= ffpa_pkg::STATUS_OK;
            block_address <= req_addr;
            page_count    <= 11'(need);
            out_valid     <= 1'b1;
            state         <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid == (state == S_OUT)) else $error("out_valid out of step");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ffpa_pkg::STATUS_OK |-> page_count == '0 && block_address == '0)
    else $error("failure carries data");
  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ffpa_pkg::STATUS_OK |-> page_count != '0 || need > CW'(2047))
    else $error("success with no pages");
`endif
endmodule
`default_nettype wire
